/* rtl/core/bpk_pkg.sv */
// ----------------------------------------------------------------------------
// bpk_pkg
// Shared types and constants for the bit packer with 0xFF bit stuffing.
// ----------------------------------------------------------------------------
package bpk_pkg;

  // Width of the capacity register and byte counter
  localparam int CAP_W = 21;

  // Hard limit on stream length, also the capacity reset value
  localparam logic [CAP_W-1:0] MAX_BYTES = 21'd1048576;

  // Byte that triggers a stuffed zero in the next byte
  localparam logic [7:0] STUFF_BYTE = 8'hFF;

  // Free bit counts of the pending byte
  localparam logic [3:0] FREE_FULL    = 4'd8;
  localparam logic [3:0] FREE_STUFFED = 4'd7;

  // Most bytes a symbol may emit
  localparam logic [3:0] SYM_MAX_BYTES = 4'd8;

  // Command codes
  localparam logic [1:0] CMD_BIT    = 2'd0;
  localparam logic [1:0] CMD_SYMBOL = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       overflow_error;
    logic       last_of_run;
  } result_t;

  // Capacity check outcome
  typedef struct packed {
    logic [CAP_W-1:0] sum;
    logic             overflow;
  } cap_status_t;

endpackage

/* rtl/core/bit_packer_with_ff_stuffing_unit.sv */
// Bit item that does not complete a byte: next item accepted right after.
// Completed byte or flush: accept, then the capacity check state, then the emit state.
// Symbol of n bytes: accept, capacity check, then n emits; the shared add/compare unit and the single
// output register emit one byte per cycle, stalled by out_ready.
// Synchronous active-high reset clears the bit buffer, byte count and sticky error,
// and sets the capacity register to the hard maximum.
// ----------------------------------------------------------------------------
// bit_packer_with_ff_stuffing_unit
// Packs bits MSB first into bytes with a stuffed zero after 0xFF, emits symbol
// bytes and flushes, all counted against a capacity limit with sticky overflow.
// ----------------------------------------------------------------------------
module bit_packer_with_ff_stuffing_unit (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bpk_pkg::CAP_W-1:0] capacity_bytes,
  // input transactions
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic                      bit_value,
  input  logic [63:0]               symbol_value,
  input  logic [3:0]                symbol_bytes,
  // output transactions
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic                      overflow_error,
  output logic                      last_of_run
);

  bpk_pkg::state_t             state, state_next;
  logic [bpk_pkg::CAP_W-1:0]   capacity;
  logic [bpk_pkg::CAP_W-1:0]   bytes_written;
  logic [7:0]                  bit_buffer;
  logic [3:0]                  bits_free;
  logic                        sticky_error;
  logic [1:0]                  cmd_reg;
  logic [63:0]                 symbol;
  logic [3:0]                  need;
  logic [3:0]                  cnt;

  bpk_pkg::cap_status_t        cap;
  bpk_pkg::result_t            result;
  logic                        push;
  logic                        free;
  logic                        accept;
  logic [3:0]                  free_norm;
  logic [3:0]                  free_dec;
  logic [7:0]                  buf_bit;
  logic [3:0]                  nbytes_sat;
  logic [2:0]                  byte_sel;
  logic [7:0]                  sym_byte;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == bpk_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bpk_pkg::MAX_BYTES;
    end else if (cfg_valid) begin
      capacity <= capacity_bytes;
    end
  end

  // Shared capacity check
  bpk_cap_unit u_cap (
    .bytes_written (bytes_written),
    .need          (need),
    .capacity      (capacity),
    .status        (cap)
  );

  // Bit insertion for the incoming bit
  assign free_norm  = (bits_free == 4'd0 || bits_free > bpk_pkg::FREE_FULL) ?
                      bpk_pkg::FREE_FULL : bits_free;
  assign free_dec   = free_norm - 4'd1;
  assign buf_bit    = bit_buffer | ({7'd0, bit_value} << free_dec[2:0]);
  assign nbytes_sat = (symbol_bytes > bpk_pkg::SYM_MAX_BYTES) ?
                      bpk_pkg::SYM_MAX_BYTES : symbol_bytes;

  // Symbol byte select, most significant of the requested bytes first
  assign byte_sel = 3'(cnt - 4'd1);
  always_comb begin
    sym_byte = symbol[8*byte_sel +: 8];
  end

  // Sequencer next state and result
  always_comb begin
    state_next = state;
    push       = 1'b0;
    result     = '0;
    case (state)
      bpk_pkg::S_IDLE: begin
        if (accept && !sticky_error) begin
          case (cmd)
            bpk_pkg::CMD_BIT: begin
              if (free_dec == 4'd0) begin
                state_next = bpk_pkg::S_CHECK;
              end
            end
            bpk_pkg::CMD_SYMBOL: begin
              state_next = bpk_pkg::S_CHECK;
            end
            bpk_pkg::CMD_FLUSH: begin
              if (bits_free != bpk_pkg::FREE_FULL) begin
                state_next = bpk_pkg::S_CHECK;
              end
            end
            default: begin
              state_next = bpk_pkg::S_IDLE;
            end
          endcase
        end
      end
      bpk_pkg::S_CHECK: begin
        if (cap.overflow) begin
          if (free) begin
            push                  = 1'b1;
            result.overflow_error = 1'b1;
            result.last_of_run    = 1'b1;
            state_next            = bpk_pkg::S_IDLE;
          end
        end else if (need == 4'd0) begin
          state_next = bpk_pkg::S_IDLE;
        end else begin
          state_next = bpk_pkg::S_EMIT;
        end
      end
      bpk_pkg::S_EMIT: begin
        if (free) begin
          push               = 1'b1;
          result.out_byte    = (cmd_reg == bpk_pkg::CMD_SYMBOL) ? sym_byte : bit_buffer;
          result.last_of_run = (cnt == 4'd1);
          if (cnt == 4'd1) begin
            state_next = bpk_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = bpk_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bpk_pkg::S_IDLE;
      sticky_error  <= 1'b0;
      bytes_written <= '0;
      bit_buffer    <= '0;
      bits_free     <= bpk_pkg::FREE_FULL;
    end else begin
      state <= state_next;
      // bit item updates the pending byte at accept
      if (state == bpk_pkg::S_IDLE && accept && !sticky_error && cmd == bpk_pkg::CMD_BIT) begin
        bit_buffer <= buf_bit;
        bits_free  <= free_dec;
      end
      // capacity check outcome
      if (state == bpk_pkg::S_CHECK) begin
        if (cap.overflow) begin
          if (free) begin
            sticky_error <= 1'b1;
          end
        end else begin
          bytes_written <= cap.sum;
        end
      end
      // pending byte leaves the buffer
      if (state == bpk_pkg::S_EMIT && free && cmd_reg != bpk_pkg::CMD_SYMBOL) begin
        bit_buffer <= '0;
        if (cmd_reg == bpk_pkg::CMD_BIT && bit_buffer == bpk_pkg::STUFF_BYTE) begin
          bits_free <= bpk_pkg::FREE_STUFFED;
        end else begin
          bits_free <= bpk_pkg::FREE_FULL;
        end
      end
    end
  end

  // Item payload and byte counter
  always_ff @(posedge clk) begin
    if (state == bpk_pkg::S_IDLE && accept) begin
      cmd_reg <= cmd;
      symbol  <= symbol_value;
      need    <= (cmd == bpk_pkg::CMD_SYMBOL) ? nbytes_sat : 4'd1;
    end
    if (state == bpk_pkg::S_CHECK) begin
      cnt <= need;
    end else if (state == bpk_pkg::S_EMIT && free) begin
      cnt <= cnt - 4'd1;
    end
  end

  // Output stage
  bpk_out_reg u_out (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .result         (result),
    .free           (free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .overflow_error (overflow_error),
    .last_of_run    (last_of_run)
  );

  // Checks
  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    sticky_error |=> sticky_error)
    else $error("sticky error cleared without reset");

  a_err_sets_sticky: assert property (@(posedge clk) disable iff (rst)
    (push && result.overflow_error) |=> sticky_error)
    else $error("error result without sticky error");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == bpk_pkg::S_EMIT) |-> (cnt != 4'd0 && cnt <= bpk_pkg::SYM_MAX_BYTES))
    else $error("emit count out of range");

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (push && result.overflow_error) |-> (result.last_of_run && result.out_byte == 8'd0))
    else $error("malformed error result");

endmodule

/* rtl/core/bpk_cap_unit.sv */
// ----------------------------------------------------------------------------
// bpk_cap_unit
// Shared add/compare unit: running byte count plus request against the limit.
// ----------------------------------------------------------------------------
module bpk_cap_unit (
  input  logic [bpk_pkg::CAP_W-1:0] bytes_written,
  input  logic [3:0]                need,
  input  logic [bpk_pkg::CAP_W-1:0] capacity,
  output bpk_pkg::cap_status_t      status
);

  logic [bpk_pkg::CAP_W-1:0] limit;
  logic [bpk_pkg::CAP_W:0]   sum_wide;

  // Limit in force is the smaller of the register and the hard maximum
  assign limit = (capacity < bpk_pkg::MAX_BYTES) ? capacity : bpk_pkg::MAX_BYTES;

  // One extra bit so the sum cannot wrap before the compare
  assign sum_wide = {1'b0, bytes_written} + {{(bpk_pkg::CAP_W-3){1'b0}}, need};

  assign status.overflow = sum_wide > {1'b0, limit};
  assign status.sum      = sum_wide[bpk_pkg::CAP_W-1:0];

endmodule

/* rtl/core/bpk_out_reg.sv */
// ----------------------------------------------------------------------------
// bpk_out_reg
// Output register stage holding one result until the sink takes it.
// ----------------------------------------------------------------------------
module bpk_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bpk_pkg::result_t    result,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                overflow_error,
  output logic                last_of_run
);

  bpk_pkg::result_t held;

  // Slot can take a new result when empty or being drained this cycle
  assign free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      held <= result;
    end
  end

  assign out_byte       = held.out_byte;
  assign overflow_error = held.overflow_error;
  assign last_of_run    = held.last_of_run;

endmodule
